// ===== rtl/echo_request_tracker_assert.svh =====
// Assertion macros used by the slot table RTL.
// Each one samples on clk and is disabled while arst_n is low.
`ifndef ECHO_REQUEST_TRACKER_ASSERT_SVH
`define ECHO_REQUEST_TRACKER_ASSERT_SVH

// Whenever cond holds, expr must hold in the same cycle.
`define ERT_ASSERT_IMP(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("tracker assertion failed");

// expr must never hold.
`define ERT_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("tracker assertion failed");

`endif

// ===== rtl/ert_pkg.sv =====
package ert_pkg;

	localparam int SLOTS = 128;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int SLOT_OUT_W = 7;

	localparam int USEC_PER_SEC = 1000000;
	localparam int MS_PER_SEC = 1000;
	localparam int MIN_REPLY_LEN = 8;
	localparam int ECHO_REPLY_TYPE = 0;

	// floor(x / 1000) == (x * DIV1000_MUL) >> DIV1000_SHIFT for every x below 2**21.
	localparam int DIV1000_MUL = 1073742;
	localparam int DIV1000_SHIFT = 30;

	// Magnitude of the microsecond difference and width of its millisecond quotient.
	localparam int RTT_MAG_W = 21;
	localparam int RTT_Q_W = 11;

	typedef enum logic [2:0] {
		ST_SENT    = 3'd0,
		ST_FULL    = 3'd1,
		ST_MATCH   = 3'd2,
		ST_SHORT   = 3'd3,
		ST_FOREIGN = 3'd4,
		ST_UNKNOWN = 3'd5
	} status_t;

	typedef struct packed {
		logic [15:0] seq;
		logic [31:0] sec;
		logic [19:0] usec;
	} slot_entry_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic             set_busy;
		logic             clr_busy;
		logic [IDX_W-1:0] wr_addr;
		slot_entry_t      wr_data;
	} tbl_ctrl_t;

	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] idx;
		logic             busy;
		slot_entry_t      entry;
	} tbl_rd_t;

endpackage

// ===== rtl/ert_if.sv =====
interface ert_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] now_sec;
	logic [19:0] now_usec;
	logic [7:0]  reply_type;
	logic [15:0] reply_id;
	logic [15:0] reply_seq;
	logic [15:0] reply_len;

	modport source (
		output valid, op, now_sec, now_usec, reply_type, reply_id, reply_seq, reply_len,
		input  ready
	);
	modport sink (
		input  valid, op, now_sec, now_usec, reply_type, reply_id, reply_seq, reply_len,
		output ready
	);
endinterface

interface ert_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] seq_out;
	logic [6:0]  slot_out;
	logic [31:0] rtt_ms;
	logic [15:0] sent_count;
	logic [15:0] recv_count;

	modport source (
		output valid, status, seq_out, slot_out, rtt_ms, sent_count, recv_count,
		input  ready
	);
	modport sink (
		input  valid, status, seq_out, slot_out, rtt_ms, sent_count, recv_count,
		output ready
	);
endinterface

interface ert_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (
		output valid, data,
		input  ready
	);
	modport sink (
		input  valid, data,
		output ready
	);
endinterface

// ===== rtl/ert_slot_table.sv =====
`include "echo_request_tracker_assert.svh"

module ert_slot_table (
	input  logic                clk,
	input  logic                arst_n,
	input  ert_pkg::tbl_ctrl_t  ctrl,
	output ert_pkg::tbl_rd_t    rd
);

	ert_pkg::slot_entry_t mem [ert_pkg::SLOTS];
	logic [ert_pkg::SLOTS-1:0] busy_q;

	logic                      rd_valid_s1;
	logic [ert_pkg::IDX_W-1:0] rd_idx_s1;
	logic                      rd_busy_s1;
	ert_pkg::slot_entry_t      rd_entry_s1;

	// Entry storage has no reset; only busy slots are ever read back as data.
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
		if (ctrl.rd_en) begin
			rd_entry_s1 <= mem[ctrl.rd_addr];
			rd_busy_s1  <= busy_q[ctrl.rd_addr];
			rd_idx_s1   <= ctrl.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= ctrl.rd_en;
			if (ctrl.set_busy) begin
				busy_q[ctrl.wr_addr] <= 1'b1;
			end else if (ctrl.clr_busy) begin
				busy_q[ctrl.wr_addr] <= 1'b0;
			end
		end
	end

	assign rd.valid = rd_valid_s1;
	assign rd.idx   = rd_idx_s1;
	assign rd.busy  = rd_busy_s1;
	assign rd.entry = rd_entry_s1;

	`ERT_ASSERT_NEVER(a_set_and_clear, ctrl.set_busy && ctrl.clr_busy)
	`ERT_ASSERT_IMP(a_claim_free_slot, ctrl.set_busy, !busy_q[ctrl.wr_addr])
	`ERT_ASSERT_IMP(a_free_busy_slot, ctrl.clr_busy, busy_q[ctrl.wr_addr])
	`ERT_ASSERT_IMP(a_write_only_on_claim, ctrl.wr_en, ctrl.set_busy)

endmodule

// ===== rtl/ert_rtt.sv =====
module ert_rtt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] now_sec,
	input  logic [19:0] now_usec,
	input  logic [31:0] then_sec,
	input  logic [19:0] then_usec,
	output logic        done,
	output logic [31:0] rtt_ms
);

	logic signed [33:0]               ds_raw;
	logic signed [21:0]               dus_raw;
	logic signed [33:0]               ds_adj;
	logic signed [21:0]               dus_adj;
	logic                             neg;
	logic [ert_pkg::RTT_MAG_W-1:0]    mag;

	logic                             valid_s1;
	logic signed [33:0]               ds_s1;
	logic                             neg_s1;
	logic [ert_pkg::RTT_MAG_W-1:0]    mag_s1;

	logic [2*ert_pkg::RTT_MAG_W-1:0]  prod;
	logic signed [43:0]               dsk;
	logic                             valid_s2;
	logic [ert_pkg::RTT_Q_W-1:0]      q_s2;
	logic                             neg_s2;
	logic signed [43:0]               dsk_s2;

	logic signed [44:0]               qx;
	logic signed [44:0]               ms;
	logic                             valid_s3;
	logic [31:0]                      rtt_s3;

	// Seconds and microseconds differences with one borrow of a second.
	always_comb begin
		ds_raw  = $signed({2'b00, now_sec}) - $signed({2'b00, then_sec});
		dus_raw = $signed({2'b00, now_usec}) - $signed({2'b00, then_usec});
		if (dus_raw < 0) begin
			ds_adj  = ds_raw - 34'sd1;
			dus_adj = dus_raw + 22'(ert_pkg::USEC_PER_SEC);
		end else begin
			ds_adj  = ds_raw;
			dus_adj = dus_raw;
		end
		// Out-of-range microsecond inputs can leave the difference negative;
		// the quotient then truncates toward zero.
		neg = dus_adj[21];
		mag = neg ? ert_pkg::RTT_MAG_W'(-dus_adj) : ert_pkg::RTT_MAG_W'(dus_adj);
	end

	always_comb begin
		prod = (2*ert_pkg::RTT_MAG_W)'(mag_s1) *
			(2*ert_pkg::RTT_MAG_W)'(ert_pkg::DIV1000_MUL);
		dsk  = 44'(ds_s1) * 44'(ert_pkg::MS_PER_SEC);
	end

	always_comb begin
		qx = $signed({34'd0, q_s2});
		if (neg_s2) begin
			qx = -qx;
		end
		ms = 45'(dsk_s2) + qx;
	end

	always_ff @(posedge clk) begin
		ds_s1  <= ds_adj;
		neg_s1 <= neg;
		mag_s1 <= mag;
		q_s2   <= prod[ert_pkg::DIV1000_SHIFT +: ert_pkg::RTT_Q_W];
		neg_s2 <= neg_s1;
		dsk_s2 <= dsk;
		if (ms[44]) begin
			rtt_s3 <= '0;
		end else if (|ms[43:32]) begin
			rtt_s3 <= '1;
		end else begin
			rtt_s3 <= ms[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign done   = valid_s3;
	assign rtt_ms = rtt_s3;

endmodule

// ===== rtl/echo_request_tracker.sv =====
// Echo request tracker: keeps a table of outstanding echo requests.
// Channel req carries one item per send (op 0) or received reply (op 1).
// Channel rsp returns exactly one result item per req item, in order.
// Channel cfg writes own_id, the identifier replies must carry; it is
// always ready and should be written only while no item is in flight.
// Items are handled one at a time. A send scans the slot memory one entry
// per cycle from slot 0 until it finds a free slot; a reply scans until it
// finds a busy slot with its sequence number. The scan through the
// single-ported slot memory sets the time from accept to result, which
// grows with the index of the slot that hits; a miss scans every slot,
// and a match also passes the round trip pipeline. Short and foreign
// replies skip the scan. req is ready again the cycle after the result
// is loaded into the output register.
// If rsp stalls, one finished result waits in the output register while the
// next item is accepted and processed; that item then waits for the register.
// Reset clears all slots to free, both counters and own_id to zero, with no
// clearing pass.
module echo_request_tracker (
	input  logic      clk,
	input  logic      arst_n,
	ert_req_if.sink   req,
	ert_rsp_if.source rsp,
	ert_cfg_if.sink   cfg
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RTT,
		S_DONE
	} state_t;

	state_t state_q;

	logic [15:0] own_id_q;
	logic [15:0] sent_cnt_q;
	logic [15:0] recv_cnt_q;

	logic                      send_q;
	logic [31:0]               sec_q;
	logic [19:0]               usec_q;
	logic [15:0]               seq_q;
	logic [ert_pkg::CNT_W-1:0] scan_q;

	ert_pkg::status_t                status_q;
	logic [ert_pkg::SLOT_OUT_W-1:0]  slot_q;
	logic [31:0]                     rtt_q;

	logic                            rsp_valid_q;
	ert_pkg::status_t                out_status_q;
	logic [15:0]                     out_seq_q;
	logic [ert_pkg::SLOT_OUT_W-1:0]  out_slot_q;
	logic [31:0]                     out_rtt_q;
	logic [15:0]                     out_sent_q;
	logic [15:0]                     out_recv_q;

	ert_pkg::tbl_ctrl_t tbl_ctrl;
	ert_pkg::tbl_rd_t   tbl_rd;

	logic        accept;
	logic        in_short;
	logic        in_foreign;
	logic        hit;
	logic        scan_end;
	logic        rtt_start;
	logic        rtt_done;
	logic [31:0] rtt_ms;
	logic        rsp_free;

	ert_slot_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tbl_ctrl),
		.rd     (tbl_rd)
	);

	ert_rtt u_rtt (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rtt_start),
		.now_sec   (sec_q),
		.now_usec  (usec_q),
		.then_sec  (tbl_rd.entry.sec),
		.then_usec (tbl_rd.entry.usec),
		.done      (rtt_done),
		.rtt_ms    (rtt_ms)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
		end else if (cfg.valid) begin
			own_id_q <= cfg.data;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	always_comb begin
		in_short   = req.reply_len < 16'(ert_pkg::MIN_REPLY_LEN);
		in_foreign = (req.reply_type != 8'(ert_pkg::ECHO_REPLY_TYPE)) ||
			(req.reply_id != own_id_q);
	end

	// Read data of the slot memory arrives in the cycle after the address.
	always_comb begin
		hit = (state_q == S_SCAN) && tbl_rd.valid &&
			(send_q ? !tbl_rd.busy : (tbl_rd.busy && (tbl_rd.entry.seq == seq_q)));
		scan_end = (state_q == S_SCAN) && tbl_rd.valid &&
			(tbl_rd.idx == ert_pkg::IDX_W'(ert_pkg::SLOTS - 1));
		rtt_start = hit && !send_q;

		tbl_ctrl          = '0;
		tbl_ctrl.rd_en    = (state_q == S_SCAN) && !hit &&
			(scan_q < ert_pkg::CNT_W'(ert_pkg::SLOTS));
		tbl_ctrl.rd_addr  = scan_q[ert_pkg::IDX_W-1:0];
		tbl_ctrl.wr_addr  = tbl_rd.idx;
		tbl_ctrl.wr_data  = '{seq: seq_q, sec: sec_q, usec: usec_q};
		tbl_ctrl.wr_en    = hit && send_q;
		tbl_ctrl.set_busy = hit && send_q;
		tbl_ctrl.clr_busy = hit && !send_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			sent_cnt_q  <= '0;
			recv_cnt_q  <= '0;
			scan_q      <= '0;
		end else begin
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						send_q   <= !req.op;
						sec_q    <= req.now_sec;
						usec_q   <= req.now_usec;
						slot_q   <= '0;
						rtt_q    <= '0;
						scan_q   <= '0;
						if (!req.op) begin
							seq_q   <= sent_cnt_q;
							state_q <= S_SCAN;
						end else if (in_short) begin
							seq_q    <= '0;
							status_q <= ert_pkg::ST_SHORT;
							state_q  <= S_DONE;
						end else if (in_foreign) begin
							seq_q    <= req.reply_seq;
							status_q <= ert_pkg::ST_FOREIGN;
							state_q  <= S_DONE;
						end else begin
							seq_q   <= req.reply_seq;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (tbl_ctrl.rd_en) begin
						scan_q <= scan_q + 1'b1;
					end
					if (hit) begin
						slot_q <= ert_pkg::SLOT_OUT_W'(tbl_rd.idx);
						if (send_q) begin
							status_q   <= ert_pkg::ST_SENT;
							sent_cnt_q <= sent_cnt_q + 1'b1;
							state_q    <= S_DONE;
						end else begin
							status_q   <= ert_pkg::ST_MATCH;
							recv_cnt_q <= recv_cnt_q + 1'b1;
							state_q    <= S_RTT;
						end
					end else if (scan_end) begin
						if (send_q) begin
							status_q   <= ert_pkg::ST_FULL;
							sent_cnt_q <= sent_cnt_q + 1'b1;
						end else begin
							status_q <= ert_pkg::ST_UNKNOWN;
						end
						state_q <= S_DONE;
					end
				end
				S_RTT: begin
					if (rtt_done) begin
						rtt_q   <= rtt_ms;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						out_status_q <= status_q;
						out_seq_q    <= seq_q;
						out_slot_q   <= slot_q;
						out_rtt_q    <= rtt_q;
						out_sent_q   <= sent_cnt_q;
						out_recv_q   <= recv_cnt_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.seq_out    = out_seq_q;
	assign rsp.slot_out   = out_slot_q;
	assign rsp.rtt_ms     = out_rtt_q;
	assign rsp.sent_count = out_sent_q;
	assign rsp.recv_count = out_recv_q;

endmodule
